// ===== rtl/mbps_pkg.sv =====
// Shared types, constants and register codes of the masked byte pattern scanner.
package mbps_pkg;

  // Longest window the cell row can hold, and the room of the pattern registers
  localparam int PATTERN_MAX  = 16;
  localparam int PATTERN_ROOM = 16;
  localparam int LEN_LIMIT    = (PATTERN_MAX < PATTERN_ROOM) ? PATTERN_MAX : PATTERN_ROOM;
  localparam int HIST_DEPTH   = PATTERN_MAX - 1;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 5;
  localparam int PIDX_W  = $clog2(PATTERN_ROOM);
  localparam int ADDR_W  = 32;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 3;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_PATTERN_LOW    = 3'd0,
    CFG_PATTERN_HIGH   = 3'd1,
    CFG_CARE_MASK      = 3'd2,
    CFG_PATTERN_LENGTH = 3'd3,
    CFG_REGION_BASE    = 3'd4,
    CFG_RESULT_OFFSET  = 3'd5
  } cfg_idx_e;

  // Pattern set-up seen by the scan row
  typedef struct packed {
    logic [PATTERN_ROOM*BYTE_W-1:0] pattern;
    logic [PATTERN_ROOM-1:0]        care;
    logic [LEN_W-1:0]               len;
  } scan_cfg_t;

  // Outcome of one request, handed to the result stage
  typedef struct packed {
    logic              valid;
    logic              found;
    logic [ADDR_W-1:0] pos;
  } scan_res_t;

endpackage

// ===== rtl/mbps_cell.sv =====
// One window cell: holds a history byte, passes it on, and checks it.
module mbps_cell
  import mbps_pkg::*;
(
  input  logic              clk_i,
  input  logic              shift_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic [BYTE_W-1:0] exp_i,
  input  logic              chk_i,
  output logic [BYTE_W-1:0] byte_o,
  output logic              hit_o
);

  logic [BYTE_W-1:0] byte_q;

  // Take the neighbour's byte when the window advances
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  // A wildcard or unused position always agrees
  assign hit_o  = !chk_i || (byte_q == exp_i);

endmodule

// ===== rtl/mbps_scan.sv =====
// Window row of cells, region byte counter and match decision.
module mbps_scan
  import mbps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scan_cfg_t         cfg_i,
  input  logic              acc_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              last_byte_i,
  output scan_res_t         res_o
);

  logic [BYTE_W-1:0]      chain_w [PATTERN_MAX];
  logic [BYTE_W-1:0]      exp_a   [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] chk_a;
  logic [PATTERN_MAX-1:0] hits;
  logic                   len_ok;
  logic [ADDR_W-1:0]      seen_q, seen_d, count;
  logic                   reported_q, reported_d;
  logic                   match;
  logic                   shift;

  assign len_ok = (cfg_i.len != '0) && (int'(cfg_i.len) <= LEN_LIMIT);

  // Align the pattern so that window position p (0 = newest byte) meets byte len-1-p
  always_comb begin
    logic [PIDX_W-1:0] idx;
    for (int p = 0; p < PATTERN_MAX; p++) begin
      idx      = PIDX_W'(int'(cfg_i.len) - 1 - p);
      exp_a[p] = cfg_i.pattern[BYTE_W*idx +: BYTE_W];
      chk_a[p] = len_ok && (int'(cfg_i.len) > p) && cfg_i.care[idx];
    end
  end

  // Newest byte enters the row straight from the request
  assign chain_w[0] = data_byte_i;
  assign hits[0]    = !chk_a[0] || (data_byte_i == exp_a[0]);

  // Row of history cells, each handing its byte to the next
  for (genvar k = 0; k < HIST_DEPTH; k++) begin : g_cell
    mbps_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .byte_i (chain_w[k]),
      .exp_i  (exp_a[k+1]),
      .chk_i  (chk_a[k+1]),
      .byte_o (chain_w[k+1]),
      .hit_o  (hits[k+1])
    );
  end

  // Saturating count including this byte
  assign count = (seen_q == '1) ? seen_q : seen_q + ADDR_W'(1);
  assign match = len_ok && (count >= ADDR_W'(cfg_i.len)) && (&hits);
  assign shift = acc_i && !reported_q && !match;

  // Advance the counter and the reported flag; drop both at the region end
  always_comb begin
    seen_d     = seen_q;
    reported_d = reported_q;
    if (acc_i) begin
      if (!reported_q) begin
        seen_d = count;
        if (match) begin
          reported_d = 1'b1;
        end
      end
      if (last_byte_i) begin
        seen_d     = '0;
        reported_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else begin
      seen_q     <= seen_d;
      reported_q <= reported_d;
    end
  end

  // One result for the first match, or a miss at the end of the region
  assign res_o.valid = acc_i && !reported_q && (match || last_byte_i);
  assign res_o.found = !reported_q && match;
  assign res_o.pos   = count - ADDR_W'(cfg_i.len);

endmodule

// ===== rtl/masked_byte_pattern_scan.sv =====
// Top level of the masked byte pattern scanner: registers, scan row, result stages.
//
//   channel  direction  handshake                  payload
//   in       to block   in_valid_i / in_stall_o    data_byte_i, last_byte_i
//   out      from block out_valid_o / out_stall_i  found_o, match_address_o
//   cfg      to block   cfg_we_i                   cfg_index_i, cfg_data_i
//
// One request is taken every cycle while in_stall_o is low; the compare over
// the cell row decides in the cycle a byte arrives, and a result then passes
// the decision register and the address add into the output register.
// Reset is asynchronous and clears registers, counter and result stages.
// A stalled output holds; the input stalls only once both stages are full.
module masked_byte_pattern_scan
  import mbps_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CIDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              found_o,
  output logic [ADDR_W-1:0] match_address_o
);

  logic [63:0]             pat_lo_q, pat_hi_q;
  logic [PATTERN_ROOM-1:0] care_q;
  logic [LEN_W-1:0]        len_q;
  logic [ADDR_W-1:0]       base_q, offset_q;
  scan_cfg_t               scan_cfg;
  scan_res_t               res;
  logic                    acc;
  logic                    mid_ready, out_ready;
  logic                    mid_valid_q, mid_found_q;
  logic [ADDR_W-1:0]       mid_pos_q;
  logic                    out_valid_q, out_found_q;
  logic [ADDR_W-1:0]       out_addr_q;

  // Write the configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q <= '0;
      pat_hi_q <= '0;
      care_q   <= '0;
      len_q    <= '0;
      base_q   <= '0;
      offset_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PATTERN_LOW:    pat_lo_q <= cfg_data_i;
        CFG_PATTERN_HIGH:   pat_hi_q <= cfg_data_i;
        CFG_CARE_MASK:      care_q   <= cfg_data_i[PATTERN_ROOM-1:0];
        CFG_PATTERN_LENGTH: len_q    <= cfg_data_i[LEN_W-1:0];
        CFG_REGION_BASE:    base_q   <= cfg_data_i[ADDR_W-1:0];
        CFG_RESULT_OFFSET:  offset_q <= cfg_data_i[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign scan_cfg.pattern = {pat_hi_q, pat_lo_q};
  assign scan_cfg.care    = care_q;
  assign scan_cfg.len     = len_q;

  // Handshake: each stage advances when the one after it can take data
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign mid_ready  = !mid_valid_q || out_ready;
  assign in_stall_o = !mid_ready;
  assign acc        = in_valid_i && mid_ready;

  mbps_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (scan_cfg),
    .acc_i      (acc),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .res_o      (res)
  );

  // Register the decision
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (mid_ready) begin
      mid_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_ready && res.valid) begin
      mid_found_q <= res.found;
      mid_pos_q   <= res.pos;
    end
  end

  // Form the address and load the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && mid_valid_q) begin
      out_found_q <= mid_found_q;
      out_addr_q  <= mid_found_q ? (base_q + offset_q + mid_pos_q) : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = out_found_q;
  assign match_address_o = out_addr_q;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the masked byte pattern scanner.
`timescale 1ns / 100ps

module tb;
  import mbps_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 9;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_LIMIT    = 40;

  // One result as the scanner should give it
  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] address;
  } scan_result_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic [CIDX_W-1:0] cfg_index_i     = '0;
  logic [CFG_W-1:0]  cfg_data_i      = '0;
  logic              in_valid_i      = 1'b0;
  logic              in_stall_o;
  logic [BYTE_W-1:0] data_byte_i     = '0;
  logic              last_byte_i     = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i     = 1'b0;
  logic              found_o;
  logic [ADDR_W-1:0] match_address_o;

  // Scanner state as predicted
  logic [PATTERN_ROOM*BYTE_W-1:0] scan_pattern = '0;
  logic [PATTERN_ROOM-1:0]        scan_care    = '0;
  logic [LEN_W-1:0]               scan_len     = '0;
  logic [ADDR_W-1:0]              scan_base    = '0;
  logic [ADDR_W-1:0]              scan_offset  = '0;
  logic [BYTE_W-1:0]              window_bytes [0:HIST_DEPTH-1];
  logic [31:0]                    region_count = '0;
  logic                           region_done  = 1'b0;

  scan_result_t expected_results [$];
  scan_result_t oldest_result;

  int          mismatch_count = 0;
  int          in_idle_pct    = 0;
  int          out_idle_pct   = 0;
  int unsigned stall_request  = 0;
  int unsigned hold_left      = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned bytes_sent     = 0;

  masked_byte_pattern_scan i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .match_address_o (match_address_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  initial begin
    for (int k = 0; k < HIST_DEPTH; k++) window_bytes[k] = '0;
  end

  // Report one mismatch; keep the log short once many have been seen
  task automatic flag_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Compare the window ending in the current byte with the masked pattern
  function automatic bit window_hit(input logic [7:0] cur, input logic [31:0] count);
    logic [7:0] b;
    if (scan_len == 0 || scan_len > LEN_LIMIT) return 1'b0;
    if (count < scan_len) return 1'b0;
    for (int j = 0; j < scan_len; j++) begin
      b = (j == scan_len - 1) ? cur : window_bytes[scan_len - 2 - j];
      if (scan_care[j] && b != scan_pattern[8*j +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Advance the predicted scan by one accepted byte and queue any result
  function automatic void predict_scan_byte(input logic [7:0] cur, input logic last);
    logic [31:0]  count;
    scan_result_t res;
    if (!region_done) begin
      count = (region_count == '1) ? region_count : region_count + 32'd1;
      if (window_hit(cur, count)) begin
        res.found   = 1'b1;
        res.address = scan_base + (count - 32'(scan_len)) + scan_offset;
        expected_results.push_back(res);
        region_done = 1'b1;
      end else begin
        for (int k = HIST_DEPTH - 1; k > 0; k--) window_bytes[k] = window_bytes[k-1];
        window_bytes[0] = cur;
      end
      region_count = count;
    end
    if (last) begin
      if (!region_done) begin
        res.found   = 1'b0;
        res.address = '0;
        expected_results.push_back(res);
      end
      for (int k = 0; k < HIST_DEPTH; k++) window_bytes[k] = '0;
      region_count = '0;
      region_done  = 1'b0;
    end
  endfunction

  // Offer one byte, hold it until taken, then idle at random
  task automatic send_scan_byte(input logic [7:0] value, input logic is_last);
    in_valid_i  <= 1'b1;
    data_byte_i <= value;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (in_stall_o);
    predict_scan_byte(value, is_last);
    bytes_sent++;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Drop the request and wait until every expected result is out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      CFG_PATTERN_LOW:    scan_pattern[63:0]   = value;
      CFG_PATTERN_HIGH:   scan_pattern[127:64] = value;
      CFG_CARE_MASK:      scan_care            = value[15:0];
      CFG_PATTERN_LENGTH: scan_len             = value[4:0];
      CFG_REGION_BASE:    scan_base            = value[31:0];
      CFG_RESULT_OFFSET:  scan_offset          = value[31:0];
      default: ;
    endcase
  endtask

  // Write all six registers once the scanner is idle
  task automatic apply_config(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [15:0] care, input logic [4:0] len,
                              input logic [31:0] base, input logic [31:0] offs);
    wait_drained();
    write_reg(CFG_PATTERN_LOW, lo);
    write_reg(CFG_PATTERN_HIGH, hi);
    write_reg(CFG_CARE_MASK, {48'd0, care});
    write_reg(CFG_PATTERN_LENGTH, {59'd0, len});
    write_reg(CFG_REGION_BASE, {32'd0, base});
    write_reg(CFG_RESULT_OFFSET, {32'd0, offs});
    cfg_we_i <= 1'b0;
  endtask

  // Reset registers give length zero: the region must end with no match
  task automatic test_zero_length();
    send_scan_byte(8'h00, 1'b0);
    send_scan_byte(8'hFF, 1'b1);
  endtask

  // Wildcard in the middle, address wraps, bytes after the match are dropped
  task automatic test_wildcard_match();
    apply_config(64'h0000_0000_003C_77A5, 64'h0, 16'h0005, 5'd3,
                 32'hFFFF_FFF0, 32'h0000_0020);
    send_scan_byte(8'h11, 1'b0);
    send_scan_byte(8'hA5, 1'b0);
    send_scan_byte(8'h99, 1'b0);
    send_scan_byte(8'h3C, 1'b0);
    send_scan_byte(8'hA5, 1'b0);
    send_scan_byte(8'hFF, 1'b1);
  endtask

  task automatic test_match_on_last();
    send_scan_byte(8'hA5, 1'b0);
    send_scan_byte(8'h00, 1'b0);
    send_scan_byte(8'h3C, 1'b1);
  endtask

  // Region shorter than the pattern, then a region with no match
  task automatic test_no_match();
    send_scan_byte(8'hA5, 1'b1);
    send_scan_byte(8'h3C, 1'b0);
    send_scan_byte(8'h3C, 1'b0);
    send_scan_byte(8'hA5, 1'b1);
  endtask

  // Lengths beyond the pattern room never match, even with every byte a wildcard
  task automatic test_length_too_long();
    apply_config(64'h0, 64'h0, 16'h0000, 5'd17, 32'h0000_1000, 32'h0);
    send_scan_byte(8'h00, 1'b0);
    send_scan_byte(8'h00, 1'b1);
    apply_config(64'h0, 64'h0, 16'h0000, 5'd31, 32'h0000_1000, 32'h0);
    send_scan_byte(8'h55, 1'b1);
  endtask

  task automatic test_offset_extremes();
    apply_config(64'h0, 64'h0, 16'h0000, 5'd1, 32'h0, 32'h8000_0000);
    send_scan_byte(8'hAA, 1'b1);
    apply_config('1, '1, 16'hFFFF, 5'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_scan_byte(8'hFF, 1'b1);
  endtask

  // Pattern changed between two bytes of one region
  task automatic test_midregion_write();
    apply_config(64'h5150, 64'h0, 16'h0003, 5'd2, 32'h0000_8000, 32'hFFFF_FFFF);
    send_scan_byte(8'h50, 1'b0);
    apply_config(64'h5250, 64'h0, 16'h0003, 5'd2, 32'h0000_8000, 32'hFFFF_FFFF);
    send_scan_byte(8'h52, 1'b1);
  endtask

  // Hold the output off while one-byte regions keep coming, then pause until drained
  task automatic test_backpressure();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    apply_config(64'h0, 64'h0, 16'h0001, 5'd1, 32'h0000_1000, 32'h0);
    stall_request = 80;
    repeat (40) send_scan_byte($urandom_range(1) ? 8'h00 : 8'($urandom_range(255)), 1'b1);
    wait_drained();
  endtask

  task automatic pick_random_config();
    logic [63:0] lo, hi;
    logic [15:0] care;
    logic [4:0]  len;
    logic [31:0] base, offs;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    case ($urandom_range(7))
      0: begin lo = '0; hi = '0; end
      1: begin lo = '1; hi = '1; end
      default: ;
    endcase
    case ($urandom_range(5))
      0: care = '1;
      1: care = '0;
      default: care = 16'($urandom);
    endcase
    case ($urandom_range(9))
      0: len = 5'd0;
      1: len = 5'd16;
      2: len = 5'($urandom_range(17, 31));
      3: len = 5'($urandom_range(9, 15));
      default: len = 5'($urandom_range(1, 8));
    endcase
    case ($urandom_range(3))
      0: base = '0;
      1: base = '1;
      default: base = $urandom;
    endcase
    case ($urandom_range(4))
      0: offs = 32'h8000_0000;
      1: offs = 32'h7FFF_FFFF;
      2: offs = '0;
      default: offs = $urandom;
    endcase
    apply_config(lo, hi, care, len, base, offs);
  endtask

  // One region of random bytes, mostly with the pattern planted somewhere in it
  task automatic scan_random_region();
    logic [7:0]  region_data [0:63];
    int unsigned n, at;
    bit          plant;
    n     = ($urandom_range(15) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 20);
    plant = ($urandom_range(3) != 0);
    at    = $urandom_range(n - 1);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(1)) region_data[k] = 8'($urandom_range(255));
      else region_data[k] = scan_pattern[8*$urandom_range(15) +: 8];
    end
    if (plant && scan_len != 0 && scan_len <= LEN_LIMIT) begin
      for (int j = 0; j < scan_len; j++) begin
        if (at + j < n && scan_care[j]) region_data[at + j] = scan_pattern[8*j +: 8];
      end
    end
    for (int k = 0; k < n; k++) send_scan_byte(region_data[k], k == n - 1);
  endtask

  task automatic test_random_scan(input int in_pct, input int out_pct, input int unsigned quota);
    int unsigned stop_at, regions;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    stop_at      = bytes_sent + quota;
    regions      = 0;
    while (bytes_sent < stop_at) begin
      if (regions % 6 == 0) pick_random_config();
      else if ($urandom_range(19) == 0) wait_drained();
      scan_random_region();
      regions++;
    end
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (stall_request != 0) begin
      hold_left     = stall_request;
      stall_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result found=%0b address=%08h",
                                found_o, match_address_o));
      end else begin
        oldest_result = expected_results.pop_front();
        if (found_o !== oldest_result.found)
          flag_mismatch($sformatf("found %0b, expected %0b", found_o, oldest_result.found));
        if (match_address_o !== oldest_result.address)
          flag_mismatch($sformatf("address %08h, expected %08h",
                                  match_address_o, oldest_result.address));
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_results.size());
      $display("** masked_byte_pattern_scan: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_idle_pct  = 25;
    out_idle_pct = 83;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_length();
    test_wildcard_match();
    test_match_on_last();
    test_no_match();
    test_length_too_long();
    test_offset_extremes();
    test_midregion_write();
    test_random_scan(25, 83, 250);
    test_random_scan(83, 25, 250);
    test_backpressure();
    test_random_scan(0, 0, 260);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** masked_byte_pattern_scan: PASSED **");
    end else begin
      $display("** masked_byte_pattern_scan: FAILED **");
    end
    $finish;
  end

endmodule
